>>> hdl/fta_pkg.sv
// ----------------------------------------------------------------------------
// fta_pkg
// Shared types, codes and the key hash for the flow table with aging.
// ----------------------------------------------------------------------------
package fta_pkg;

    localparam int KEY_W  = 48;
    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int HDL_W  = 10;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_HASH,
        OP_MOD,
        OP_BASE,
        OP_PROBE_RD,
        OP_PROBE_CHK,
        OP_LINK_RD,
        OP_UNLINK_A,
        OP_UNLINK_B,
        OP_APPEND_A,
        OP_APPEND_B,
        OP_EMIT_PKT,
        OP_SW_RD,
        OP_SW_DROP,
        OP_SW_PUSH,
        OP_SW_END
    } op_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_MOD,
        ST_BASE,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_DECIDE,
        ST_LINK_RD,
        ST_UNLINK_A,
        ST_UNLINK_B,
        ST_APPEND_A,
        ST_APPEND_B,
        ST_PKT_OUT,
        ST_SW_CHECK,
        ST_SW_TEST,
        ST_SW_PUSH,
        ST_SW_END
    } state_t;

    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_SWEEP  = 1'b1;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic mod_last;
        logic match;
        logic last_way;
        logic have_free;
        logic cnt_zero;
        logic sweep_cap;
        logic expire;
        logic out_free;
    } stat_t;

    function automatic logic [63:0] mix64(input logic [63:0] v);
        logic [63:0] x;
        x = v;
        x = x ^ (x << 13);
        x = x ^ (x >> 7);
        x = x ^ (x << 17);
        return x;
    endfunction

endpackage

>>> hdl/fta_ctrl.sv
// ----------------------------------------------------------------------------
// fta_ctrl
// Sequencer for lookup, insert, age-list update and expiry sweep.
// ----------------------------------------------------------------------------
module fta_ctrl
    import fta_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_valid,
    input  logic  s_cmd,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = (s_cmd == CMD_SWEEP) ? ST_SW_CHECK : ST_HASH;
                end
            end
            ST_HASH:
            begin
                cmd.op     = OP_HASH;
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                cmd.op = OP_MOD;
                if (stat.mod_last)
                begin
                    state_next = ST_BASE;
                end
            end
            ST_BASE:
            begin
                cmd.op     = OP_BASE;
                state_next = ST_PROBE_RD;
            end
            ST_PROBE_RD:
            begin
                cmd.op     = OP_PROBE_RD;
                state_next = ST_PROBE_CHK;
            end
            ST_PROBE_CHK:
            begin
                cmd.op = OP_PROBE_CHK;
                priority if (stat.match)
                begin
                    state_next = ST_LINK_RD;
                end
                else if (stat.last_way)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    state_next = ST_PROBE_RD;
                end
            end
            ST_DECIDE:
            begin
                state_next = stat.have_free ? ST_APPEND_A : ST_PKT_OUT;
            end
            ST_LINK_RD:
            begin
                cmd.op     = OP_LINK_RD;
                state_next = ST_UNLINK_A;
            end
            ST_UNLINK_A:
            begin
                cmd.op     = OP_UNLINK_A;
                state_next = ST_UNLINK_B;
            end
            ST_UNLINK_B:
            begin
                cmd.op     = OP_UNLINK_B;
                state_next = ST_APPEND_A;
            end
            ST_APPEND_A:
            begin
                cmd.op     = OP_APPEND_A;
                state_next = ST_APPEND_B;
            end
            ST_APPEND_B:
            begin
                cmd.op     = OP_APPEND_B;
                state_next = ST_PKT_OUT;
            end
            ST_PKT_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT_PKT;
                    state_next = ST_IDLE;
                end
            end
            ST_SW_CHECK:
            begin
                if (stat.cnt_zero || stat.sweep_cap)
                begin
                    state_next = ST_SW_END;
                end
                else
                begin
                    cmd.op     = OP_SW_RD;
                    state_next = ST_SW_TEST;
                end
            end
            ST_SW_TEST:
            begin
                if (stat.expire)
                begin
                    cmd.op     = OP_SW_DROP;
                    state_next = ST_SW_PUSH;
                end
                else
                begin
                    state_next = ST_SW_END;
                end
            end
            ST_SW_PUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_SW_PUSH;
                    state_next = ST_SW_CHECK;
                end
            end
            ST_SW_END:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_SW_END;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/fta_dp.sv
// ----------------------------------------------------------------------------
// fta_dp
// Flow memories, age list, bucket hash and modulo unit, result register.
// ----------------------------------------------------------------------------
module fta_dp
    import fta_pkg::*;
#(
    parameter int BUCKETS   = 256,
    parameter int WAYS      = 4,
    parameter int MAX_SWEEP = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output stat_t              stat,
    input  logic [127:0]       s_data,
    input  logic               cfg_wr_en,
    input  logic [CFG_W-1:0]   cfg_wr_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_data,
    output logic [3:0]         m_user,
    output logic               m_last
);

    localparam int SLOTS = BUCKETS * WAYS;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int RW    = BW + 5;
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS + 1) : 1;
    localparam int NW    = $clog2(MAX_SWEEP + 1);

    localparam logic [RW-1:0] BV = RW'(BUCKETS);

    // memories
    logic              valid_mem [SLOTS];
    logic [KEY_W-1:0]  ck_mem    [SLOTS];
    logic [KEY_W-1:0]  sk_mem    [SLOTS];
    logic [TIME_W-1:0] time_mem  [SLOTS];
    logic [SW-1:0]     prev_mem  [SLOTS];
    logic [SW-1:0]     next_mem  [SLOTS];

    logic              valid_rd;
    logic [KEY_W-1:0]  ck_rd;
    logic [KEY_W-1:0]  sk_rd;
    logic [TIME_W-1:0] time_rd;
    logic [SW-1:0]     prev_rd;
    logic [SW-1:0]     next_rd;

    logic [KEY_W-1:0]  ckey_reg, ckey_next;
    logic [KEY_W-1:0]  skey_reg, skey_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [63:0]       h_reg, h_next;
    logic [BW-1:0]     rem_reg, rem_next;
    logic [3:0]        dig_reg, dig_next;
    logic [SW-1:0]     cur_reg, cur_next;
    logic [WW-1:0]     way_reg, way_next;
    logic [SW-1:0]     tgt_reg, tgt_next;
    logic              hit_reg, hit_next;
    logic              free_reg, free_next;
    logic              small_reg, small_next;
    logic [SW-1:0]     oldest_reg, oldest_next;
    logic [SW-1:0]     newest_reg, newest_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [NW-1:0]     nsw_reg, nsw_next;
    logic [CFG_W-1:0]  expire_reg, expire_next;
    logic [SW-1:0]     pend_reg, pend_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic [HDL_W-1:0]  out_hdl_reg, out_hdl_next;
    logic [3:0]        out_flags_reg, out_flags_next;
    logic              out_last_reg, out_last_next;

    logic              vm_we, vm_wd;
    logic [SW-1:0]     vm_wa;
    logic              key_we, time_we;
    logic              nx_we, pv_we;
    logic [SW-1:0]     nx_wa, nx_wd, pv_wa, pv_wd;
    logic              pr_re, lk_re;
    logic [SW-1:0]     lk_ra;

    logic [RW-1:0]     mod_t;
    logic [SW-1:0]     base;
    logic              match;
    logic              expire;
    logic [32:0]       idle;
    logic              out_free;

    function automatic logic [HDL_W-1:0] to_hdl(input logic [SW-1:0] s);
        logic [31:0] w;
        w = 32'(s);
        return w[HDL_W-1:0];
    endfunction

    always_comb
    begin
        mod_t = RW'({rem_reg, h_reg[63:60]});
        for (int k = 3; k >= 0; k--)
        begin
            if (mod_t >= (BV << k))
            begin
                mod_t = mod_t - (BV << k);
            end
        end
    end

    assign base     = SW'(32'(rem_reg) * 32'(WAYS));
    assign match    = valid_rd && (ck_rd == ckey_reg) && (sk_rd == skey_reg);
    assign idle     = {1'b0, now_reg} - {1'b0, time_rd};
    assign expire   = $signed(idle) > $signed({17'b0, expire_reg});
    assign out_free = !out_valid_reg || m_ready;

    assign stat.clear_done = (cur_reg == SW'(SLOTS - 1));
    assign stat.mod_last   = (dig_reg == 4'd15);
    assign stat.match      = match;
    assign stat.last_way   = (way_reg == WW'(WAYS - 1));
    assign stat.have_free  = free_reg;
    assign stat.cnt_zero   = (count_reg == '0);
    assign stat.sweep_cap  = (nsw_reg == NW'(MAX_SWEEP));
    assign stat.expire     = expire;
    assign stat.out_free   = out_free;

    always_comb
    begin
        ckey_next       = ckey_reg;
        skey_next       = skey_reg;
        now_next        = now_reg;
        h_next          = h_reg;
        rem_next        = rem_reg;
        dig_next        = dig_reg;
        cur_next        = cur_reg;
        way_next        = way_reg;
        tgt_next        = tgt_reg;
        hit_next        = hit_reg;
        free_next       = free_reg;
        small_next      = small_reg;
        oldest_next     = oldest_reg;
        newest_next     = newest_reg;
        count_next      = count_reg;
        nsw_next        = nsw_reg;
        expire_next     = cfg_wr_en ? cfg_wr_data : expire_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_hdl_next    = out_hdl_reg;
        out_flags_next  = out_flags_reg;
        out_last_next   = out_last_reg;
        vm_we   = 1'b0;
        vm_wa   = tgt_reg;
        vm_wd   = 1'b0;
        key_we  = 1'b0;
        time_we = 1'b0;
        nx_we   = 1'b0;
        nx_wa   = tgt_reg;
        nx_wd   = tgt_reg;
        pv_we   = 1'b0;
        pv_wa   = tgt_reg;
        pv_wd   = tgt_reg;
        pr_re   = 1'b0;
        lk_re   = 1'b0;
        lk_ra   = tgt_reg;
        unique case (cmd.op)
            OP_NONE:
            begin
            end
            OP_CLEAR:
            begin
                vm_we    = 1'b1;
                vm_wa    = cur_reg;
                cur_next = cur_reg + 1'b1;
            end
            OP_LOAD:
            begin
                ckey_next = s_data[47:0];
                skey_next = s_data[95:48];
                now_next  = s_data[127:96];
                hit_next  = 1'b0;
                free_next = 1'b0;
                nsw_next  = '0;
            end
            OP_HASH:
            begin
                h_next   = mix64(mix64({16'b0, ckey_reg}) ^ {16'b0, skey_reg});
                rem_next = '0;
                dig_next = '0;
            end
            OP_MOD:
            begin
                rem_next = mod_t[BW-1:0];
                h_next   = h_reg << 4;
                dig_next = dig_reg + 4'd1;
            end
            OP_BASE:
            begin
                cur_next = base;
                way_next = '0;
            end
            OP_PROBE_RD:
            begin
                pr_re = 1'b1;
            end
            OP_PROBE_CHK:
            begin
                if (match)
                begin
                    hit_next = 1'b1;
                    tgt_next = cur_reg;
                end
                else if (!valid_rd && !free_reg)
                begin
                    free_next = 1'b1;
                    tgt_next  = cur_reg;
                end
                cur_next = cur_reg + 1'b1;
                way_next = way_reg + 1'b1;
            end
            OP_LINK_RD:
            begin
                lk_re = 1'b1;
            end
            OP_UNLINK_A, OP_SW_DROP:
            begin
                small_next = (count_reg <= CW'(1));
                if (count_reg <= CW'(1))
                begin
                    oldest_next = '0;
                    newest_next = '0;
                    count_next  = '0;
                end
                else if (tgt_reg == oldest_reg)
                begin
                    oldest_next = next_rd;
                end
                else
                begin
                    nx_we = 1'b1;
                    nx_wa = prev_rd;
                    nx_wd = next_rd;
                end
                if (cmd.op == OP_SW_DROP)
                begin
                    vm_we = 1'b1;
                end
            end
            OP_UNLINK_B, OP_SW_PUSH:
            begin
                if (!small_reg)
                begin
                    if (tgt_reg == newest_reg)
                    begin
                        newest_next = prev_rd;
                    end
                    else
                    begin
                        pv_we = 1'b1;
                        pv_wa = next_rd;
                        pv_wd = prev_rd;
                    end
                    count_next = count_reg - 1'b1;
                end
                if (cmd.op == OP_SW_PUSH)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_hdl_next   = to_hdl(pend_reg);
                        out_flags_next = 4'b1000;
                        out_last_next  = 1'b0;
                    end
                    pend_next       = tgt_reg;
                    pend_valid_next = 1'b1;
                    nsw_next        = nsw_reg + 1'b1;
                end
            end
            OP_APPEND_A:
            begin
                if (count_reg == '0)
                begin
                    oldest_next = tgt_reg;
                end
                else
                begin
                    nx_we = 1'b1;
                    nx_wa = newest_reg;
                end
                pv_we   = 1'b1;
                pv_wd   = (count_reg == '0) ? tgt_reg : newest_reg;
                time_we = 1'b1;
                if (!hit_reg)
                begin
                    vm_we  = 1'b1;
                    vm_wd  = 1'b1;
                    key_we = 1'b1;
                end
            end
            OP_APPEND_B:
            begin
                nx_we       = 1'b1;
                newest_next = tgt_reg;
                count_next  = count_reg + 1'b1;
            end
            OP_EMIT_PKT:
            begin
                out_valid_next = 1'b1;
                out_hdl_next   = (hit_reg || free_reg) ? to_hdl(tgt_reg) : '0;
                out_flags_next = {1'b0, !hit_reg && !free_reg, !hit_reg && free_reg, hit_reg};
                out_last_next  = 1'b1;
            end
            OP_SW_RD:
            begin
                tgt_next = oldest_reg;
                lk_re    = 1'b1;
                lk_ra    = oldest_reg;
            end
            OP_SW_END:
            begin
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_hdl_next   = to_hdl(pend_reg);
                    out_flags_next = 4'b1000;
                    out_last_next  = 1'b1;
                end
                pend_valid_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg        <= '0;
            way_reg        <= '0;
            dig_reg        <= '0;
            hit_reg        <= 1'b0;
            free_reg       <= 1'b0;
            small_reg      <= 1'b0;
            oldest_reg     <= '0;
            newest_reg     <= '0;
            count_reg      <= '0;
            nsw_reg        <= '0;
            expire_reg     <= CFG_W'(300);
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cur_reg        <= cur_next;
            way_reg        <= way_next;
            dig_reg        <= dig_next;
            hit_reg        <= hit_next;
            free_reg       <= free_next;
            small_reg      <= small_next;
            oldest_reg     <= oldest_next;
            newest_reg     <= newest_next;
            count_reg      <= count_next;
            nsw_reg        <= nsw_next;
            expire_reg     <= expire_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ckey_reg      <= ckey_next;
        skey_reg      <= skey_next;
        now_reg       <= now_next;
        h_reg         <= h_next;
        rem_reg       <= rem_next;
        tgt_reg       <= tgt_next;
        pend_reg      <= pend_next;
        out_hdl_reg   <= out_hdl_next;
        out_flags_reg <= out_flags_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (vm_we)
        begin
            valid_mem[vm_wa] <= vm_wd;
        end
        if (key_we)
        begin
            ck_mem[tgt_reg] <= ckey_reg;
            sk_mem[tgt_reg] <= skey_reg;
        end
        if (time_we)
        begin
            time_mem[tgt_reg] <= now_reg;
        end
        if (nx_we)
        begin
            next_mem[nx_wa] <= nx_wd;
        end
        if (pv_we)
        begin
            prev_mem[pv_wa] <= pv_wd;
        end
        if (pr_re)
        begin
            valid_rd <= valid_mem[cur_reg];
            ck_rd    <= ck_mem[cur_reg];
            sk_rd    <= sk_mem[cur_reg];
        end
        if (lk_re)
        begin
            prev_rd <= prev_mem[lk_ra];
            next_rd <= next_mem[lk_ra];
            time_rd <= time_mem[lk_ra];
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = {6'b0, out_hdl_reg};
    assign m_user  = out_flags_reg;
    assign m_last  = out_last_reg;

endmodule

>>> hdl/flow_table_with_aging.sv
// ----------------------------------------------------------------------------
// flow_table_with_aging
// Hashed UDP flow table with fixed ways, an age list and timed expiry.
// Packet item: hash, modulo by one hash digit per step, a read and compare per
// way probed; a hit or an insert then puts the flow at the age list's newest end.
// Sweep item: drops expired flows from the oldest end; output stalls hold it.
// Ready again in the same cycle that the last result appears on the output. After
// reset a pass clears every slot of the valid map; expire_after resets to 300.
// ----------------------------------------------------------------------------
module flow_table_with_aging
    import fta_pkg::*;
#(
    parameter int BUCKETS   = 256,
    parameter int WAYS      = 4,
    parameter int MAX_SWEEP = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // client_ip, client_port, server_ip, server_port, current_time
    input  logic [127:0]       s_axis_tdata,
    // command
    input  logic               s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // entry_handle
    output logic [15:0]        m_axis_tdata,
    // hit, inserted, table_full, expired
    output logic [3:0]         m_axis_tuser,
    output logic               m_axis_tlast,
    input  logic               cfg_wr_en,
    input  logic [CFG_W-1:0]   cfg_wr_data
);

    cmd_t  cmd;
    stat_t stat;

    fta_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_cmd   (s_axis_tuser),
        .s_ready (s_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fta_dp #(
        .BUCKETS   (BUCKETS),
        .WAYS      (WAYS),
        .MAX_SWEEP (MAX_SWEEP)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .s_data      (s_axis_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_data      (m_axis_tdata),
        .m_user      (m_axis_tuser),
        .m_last      (m_axis_tlast)
    );

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("item accepted while another is in work");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EMIT_PKT || cmd.op == OP_SW_PUSH || cmd.op == OP_SW_END)
        |-> stat.out_free)
        else $error("result register overwritten");

    a_sweep_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_SW_RD) |-> !stat.sweep_cap && !stat.cnt_zero)
        else $error("sweep read past limit or empty list");

endmodule
